// ===== rtl/core/prdt_pkg.sv =====
// Package for the prescaled reload down-counter timer.
// Holds the word types, command codes, register offsets and sequencer states.
// No dependencies.
package prdt_pkg;

  // Command codes carried in the input word.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register offsets.
  localparam logic [7:0] OFS_CTL  = 8'h10;
  localparam logic [7:0] OFS_LOW  = 8'h14;
  localparam logic [7:0] OFS_HIGH = 8'h18;

  // Control register bit positions.
  localparam int unsigned CTL_ENABLE = 0;
  localparam int unsigned CTL_ZSTAT  = 1;
  localparam int unsigned CTL_ZCLR   = 2;
  localparam int unsigned CTL_INTEN  = 3;
  localparam int unsigned CTL_FAST   = 4;

  // Width of the cycle accumulator.
  localparam int unsigned ACC_W = 13;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  addr;
    logic [7:0]  wdata;
    logic [11:0] cycles;
  } in_word_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/prescaled_reload_down_timer_top.sv =====
// Prescaled reload down-counter timer with byte-wide registers.
// Depends on prdt_pkg for the word types, codes and states.
//
//   Channel | Direction | Handshake          | Word
//   in      | input     | in_valid/in_stall  | cmd, addr, wdata, cycles
//   out     | output    | out_valid/out_stall| rdata, irq
//
// A read, a write, an unused command or a tick while disabled goes from
// acceptance through the done state to the result standing in the output register.
// An enabled tick drains k prescaler periods in the tick state, then passes
// through the done state; one subtract-and-compare unit removes one period a cycle.
// At the default periods k is at most 15.
// Reset is synchronous; all timer state clears to zero.
// The next word is accepted while a result waits in the output register.
module prescaled_reload_down_timer_top #(
  parameter int unsigned SLOW_PERIOD = 2000,
  parameter int unsigned FAST_PERIOD = 400
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  prdt_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output prdt_pkg::out_word_t out_word
);
  import prdt_pkg::*;

  localparam logic [ACC_W-1:0] SLOW_CYC = ACC_W'(SLOW_PERIOD);
  localparam logic [ACC_W-1:0] FAST_CYC = ACC_W'(FAST_PERIOD);

  state_t           state_r, state_nxt;
  logic [7:0]       ctl_r;
  logic [15:0]      reload_r;
  logic [15:0]      count_r;
  logic [ACC_W-1:0] acc_r;
  out_word_t        res_r;
  out_word_t        out_word_r;
  logic             out_valid_r;

  logic             in_acc;
  logic             out_free;
  logic             load_out;
  logic [ACC_W-1:0] period;
  logic [ACC_W:0]   diff;
  logic             acc_ge;
  logic [7:0]       rd_byte;
  logic [7:0]       ctl_wr;

  // Shared unit: one subtract of the selected period, its borrow is the compare.
  assign period = ctl_r[CTL_FAST] ? FAST_CYC : SLOW_CYC;
  assign diff   = {1'b0, acc_r} - {1'b0, period};
  assign acc_ge = ~diff[ACC_W];

  // Handshake terms.
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Register read multiplexer.
  always_comb begin
    priority if (in_word.addr == OFS_CTL) begin
      rd_byte = ctl_r;
    end else if (in_word.addr == OFS_LOW) begin
      rd_byte = count_r[7:0];
    end else if (in_word.addr == OFS_HIGH) begin
      rd_byte = count_r[15:8];
    end else begin
      rd_byte = 8'h00;
    end
  end

  // New control value: status is kept unless cleared, clear-zero never stored.
  assign ctl_wr = {in_word.wdata[7:3], 1'b0,
                   ctl_r[CTL_ZSTAT] & ~in_word.wdata[CTL_ZCLR], in_word.wdata[0]};

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_word.cmd == CMD_TICK && ctl_r[CTL_ENABLE]) begin
            state_nxt = ST_TICK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_TICK: begin
        if (!acc_ge) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall = (state_r != ST_IDLE);
    load_out = (state_r == ST_DONE) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Timer state: register writes and tick accumulation on acceptance, one period drained per cycle in the tick state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r    <= '0;
      reload_r <= '0;
      count_r  <= '0;
      acc_r    <= '0;
    end else if (in_acc) begin
      unique case (in_word.cmd)
        CMD_WRITE: begin
          if (in_word.addr == OFS_CTL) begin
            ctl_r <= ctl_wr;
            if (in_word.wdata[CTL_ENABLE]) begin
              count_r <= reload_r;
              acc_r   <= '0;
            end
          end else if (in_word.addr == OFS_LOW) begin
            reload_r[7:0] <= in_word.wdata;
          end else if (in_word.addr == OFS_HIGH) begin
            reload_r[15:8] <= in_word.wdata;
          end
        end
        CMD_TICK: begin
          if (ctl_r[CTL_ENABLE]) begin
            acc_r <= acc_r + {1'b0, in_word.cycles};
          end
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_TICK && acc_ge) begin
      acc_r <= diff[ACC_W-1:0];
      if (count_r == 16'd0) begin
        count_r          <= reload_r;
        ctl_r[CTL_ZSTAT] <= 1'b1;
      end else begin
        count_r <= count_r - 16'd1;
      end
    end
  end

  // Pending result: captured on acceptance, irq raised by an enabled underflow.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r.rdata <= (in_word.cmd == CMD_READ) ? rd_byte : 8'h00;
      res_r.irq   <= 1'b0;
    end else if (state_r == ST_TICK && acc_ge && count_r == 16'd0 &&
                 ctl_r[CTL_INTEN]) begin
      res_r.irq <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A word is only taken while the sequencer is idle.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ST_IDLE)
    else $error("word accepted while sequencer busy");

  // Leaving the drain loop means the accumulator is below the period.
  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK && state_nxt == ST_DONE) |=> acc_r < period)
    else $error("accumulator not drained below period");

  // A fired interrupt always comes with the zero status set.
  a_irq_zstat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_r.irq) |-> ctl_r[CTL_ZSTAT])
    else $error("interrupt without zero status");

  // A new result enters the output register only from the done state.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result issued outside done state");

endmodule
